/* design/dmarf_pkg.sv */
package dmarf_pkg;

  localparam int CmdW   = 2;
  localparam int PortW  = 8;
  localparam int ByteW  = 8;
  localparam int ChanW  = 3;
  localparam int RegW   = 16;
  localparam int AddrW  = 24;
  localparam int LenW   = 17;
  localparam int NumCh  = 8;
  localparam int NumCtl = 2;

  localparam logic [CmdW-1:0] CMD_WRITE = 2'd0;
  localparam logic [CmdW-1:0] CMD_READ  = 2'd1;
  localparam logic [CmdW-1:0] CMD_QUERY = 2'd2;

  localparam logic [3:0] OFF_MASK  = 4'hA;
  localparam logic [3:0] OFF_MODE  = 4'hB;
  localparam logic [3:0] OFF_CLRFF = 4'hC;
  localparam logic [3:0] OFF_RESET = 4'hD;

  localparam logic [3:0] CTRL0_HI = 4'h0;
  localparam logic [2:0] CTRL1_HI = 3'b110;
  localparam logic [3:0] PAGE_HI  = 4'h8;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } dmarf_cmd_t;

  typedef struct packed {
    logic             hit;
    logic [ChanW-1:0] ch;
  } page_map_t;

  // Page port offset to channel; channels 0 and 4 have no page port.
  function automatic page_map_t page_channel(input logic [3:0] off);
    page_map_t m;
    m.hit = 1'b1;
    case (off)
      4'h3: m.ch = 3'd1;
      4'h1: m.ch = 3'd2;
      4'h2: m.ch = 3'd3;
      4'hB: m.ch = 3'd5;
      4'h9: m.ch = 3'd6;
      4'hA: m.ch = 3'd7;
      default: begin
        m.hit = 1'b0;
        m.ch  = 3'd0;
      end
    endcase
    return m;
  endfunction

endpackage

/* design/dmarf_ctrl.sv */
module dmarf_ctrl
  import dmarf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output dmarf_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  state_t state;

  assign in_ready       = (state == S_IDLE);
  assign cmd_o.capture  = in_valid && (state == S_IDLE);
  assign cmd_o.execute  = (state == S_EXEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state     <= S_RESP;
          out_valid <= 1'b1;
        end
        S_RESP: begin
          if (out_ready) begin
            state     <= S_IDLE;
            out_valid <= 1'b0;
          end
        end
        default: begin
          state     <= S_IDLE;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

/* design/dmarf_datapath.sv */
module dmarf_datapath
  import dmarf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  dmarf_cmd_t        cmd_i,
  input  logic [CmdW-1:0]   cmd,
  input  logic [PortW-1:0]  port,
  input  logic [ByteW-1:0]  wdata,
  input  logic [ChanW-1:0]  channel,
  output logic [ByteW-1:0]  rdata,
  output logic [AddrW-1:0]  xfer_address,
  output logic [LenW-1:0]   xfer_length,
  output logic              error
);

  // Captured word.
  logic [CmdW-1:0]  op;
  logic [PortW-1:0] pa;
  logic [ByteW-1:0] wd;
  logic [ChanW-1:0] qch;

  // Register file.
  logic [NumCtl-1:0]   byte_pointer;
  logic [3:0]          mask_bits [NumCtl];
  logic [RegW-1:0]     base_address [NumCh];
  logic [RegW-1:0]     transfer_count [NumCh];
  logic [ByteW-1:0]    page_byte [NumCh];
  logic [ByteW-1:0]    mode_byte [NumCh];

  logic            is_ctrl0, is_ctrl1, is_page, is_ctrl;
  logic            ctl;
  logic [3:0]      off;
  logic [ChanW-1:0] rch;
  logic [ChanW-1:0] mch;
  logic            off_ok;
  page_map_t       pmap;
  logic            wr, rd;

  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      op  <= cmd;
      pa  <= port;
      wd  <= wdata;
      qch <= channel;
    end
  end

  always_comb begin
    is_ctrl0 = (pa[7:4] == CTRL0_HI);
    is_ctrl1 = (pa[7:5] == CTRL1_HI);
    is_page  = (pa[7:4] == PAGE_HI);
    is_ctrl  = is_ctrl0 || is_ctrl1;
    ctl      = is_ctrl1;
    // The second controller's registers sit on even port addresses.
    off      = is_ctrl1 ? pa[4:1] : pa[3:0];
    rch      = {ctl, off[2:1]};
    mch      = {ctl, wd[1:0]};
    off_ok   = !off[3] || (off == OFF_MASK) || (off == OFF_MODE) ||
               (off == OFF_CLRFF) || (off == OFF_RESET);
    pmap     = page_channel(pa[3:0]);
    wr       = (op == CMD_WRITE);
    rd       = (op == CMD_READ);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pointer <= '0;
      for (int i = 0; i < NumCtl; i++) begin
        mask_bits[i] <= '0;
      end
      for (int i = 0; i < NumCh; i++) begin
        base_address[i]   <= '0;
        transfer_count[i] <= '0;
        page_byte[i]      <= '0;
        mode_byte[i]      <= '0;
      end
    end else if (cmd_i.execute && wr) begin
      if (is_ctrl) begin
        if (!off[3]) begin
          if (off[0]) begin
            if (byte_pointer[ctl]) transfer_count[rch][15:8] <= wd;
            else                   transfer_count[rch][7:0]  <= wd;
          end else begin
            if (byte_pointer[ctl]) base_address[rch][15:8] <= wd;
            else                   base_address[rch][7:0]  <= wd;
          end
          byte_pointer[ctl] <= ~byte_pointer[ctl];
        end else begin
          case (off)
            OFF_MASK:  mask_bits[ctl][wd[1:0]] <= wd[2];
            OFF_MODE:  mode_byte[mch] <= wd;
            OFF_CLRFF: byte_pointer[ctl] <= 1'b0;
            OFF_RESET: begin
              byte_pointer[ctl] <= 1'b0;
              mask_bits[ctl]    <= '0;
              for (int j = 0; j < NumCh / NumCtl; j++) begin
                base_address[{ctl, 2'(j)}]   <= '0;
                transfer_count[{ctl, 2'(j)}] <= '0;
                page_byte[{ctl, 2'(j)}]      <= '0;
                mode_byte[{ctl, 2'(j)}]      <= '0;
              end
            end
            default: ;
          endcase
        end
      end else if (is_page && pmap.hit) begin
        page_byte[pmap.ch] <= wd;
      end
    end
  end

  // Result word.
  always_ff @(posedge clk) begin
    if (cmd_i.execute) begin
      rdata        <= '0;
      xfer_address <= '0;
      xfer_length  <= '0;
      error        <= 1'b0;
      if (wr || rd) begin
        if (is_ctrl) begin
          error <= rd || !off_ok;
        end else if (is_page) begin
          if (rd && pmap.hit) rdata <= page_byte[pmap.ch];
        end else begin
          error <= 1'b1;
        end
      end else if (op == CMD_QUERY) begin
        xfer_address <= {page_byte[qch], base_address[qch]};
        xfer_length  <= {1'b0, transfer_count[qch]} + LenW'(1);
      end else begin
        error <= 1'b1;
      end
    end
  end

endmodule

/* design/isa_dma_channel_register_file_top.sv */
// Register file of two cascaded ISA DMA controllers, four channels each.
// The input channel (in_valid/in_ready) carries one bus access per word:
// cmd selects a port write, a port read or a channel transfer query, with
// port, wdata and channel as its operands. The output channel
// (out_valid/out_ready) returns exactly one result word per input word:
// rdata for page register reads, xfer_address and xfer_length for a
// query, and error for control reads, unsupported control offsets,
// unmapped ports and undefined commands.
// A word accepted in idle is captured; in the execute state it is carried
// out, the result register loads and out_valid rises, and in the respond
// state the result is held until the receiver takes it.
// One word is in flight at a time; the controller steps idle, execute and
// respond for each word. While the receiver stalls the result stays on the
// output ports and in_ready stays low.
// A synchronous reset clears every byte pointer, mask, base, count, page and
// mode register, and returns the controller to idle with no result held.
module isa_dma_channel_register_file_top
  import dmarf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CmdW-1:0]   cmd,
  input  logic [PortW-1:0]  port,
  input  logic [ByteW-1:0]  wdata,
  input  logic [ChanW-1:0]  channel,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ByteW-1:0]  rdata,
  output logic [AddrW-1:0]  xfer_address,
  output logic [LenW-1:0]   xfer_length,
  output logic              error
);

  dmarf_cmd_t dp_cmd;

  // Sequencing of each word and of the output handshake.
  dmarf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd_o     (dp_cmd)
  );

  // Port decode, register file and result register.
  dmarf_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd_i        (dp_cmd),
    .cmd          (cmd),
    .port         (port),
    .wdata        (wdata),
    .channel      (channel),
    .rdata        (rdata),
    .xfer_address (xfer_address),
    .xfer_length  (xfer_length),
    .error        (error)
  );

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import dmarf_pkg::*;

  // The fourth command code is not defined; the block answers it with an error.
  localparam logic [CmdW-1:0] CMD_UNDEF = 2'd3;

  // Cycles with no word moving on either side before the run is declared hung.
  // The slowest phases stall 80 percent of the time, the sender in one and the
  // receiver in the other, so a quiet stretch of the limit is very unlikely.
  localparam int WATCHDOG_LIMIT = 2000;

  // Random words per idling phase, and the idling mix of each phase.
  localparam int WORDS_PER_PHASE = 425;
  localparam int SEND_IDLE [4] = '{0, 80, 0, 26};
  localparam int RECV_STALL[4] = '{0, 0, 80, 26};

  // Page port offset of each channel. Channels 0 and 4 have no page port, so
  // they get offsets that decode to nothing.
  localparam logic [3:0] PAGE_OFF_OF_CH [NumCh] =
    '{4'h7, 4'h3, 4'h1, 4'h2, 4'hF, 4'hB, 4'h9, 4'hA};

  typedef struct packed {
    logic [ByteW-1:0] rdata;
    logic [AddrW-1:0] xfer_address;
    logic [LenW-1:0]  xfer_length;
    logic             error;
  } dma_result_t;

  // Keeps a shadow of both controllers, works out the result of every accepted
  // access word and compares the returned words against them in order.
  class dma_scoreboard;
    bit              byte_hi  [NumCtl];
    bit [3:0]        mask     [NumCtl];
    bit [RegW-1:0]   base     [NumCh];
    bit [RegW-1:0]   count    [NumCh];
    bit [ByteW-1:0]  page     [NumCh];
    bit [ByteW-1:0]  mode     [NumCh];
    dma_result_t     expected_results[$];
    int              failures;

    function bit write_control(int c, logic [3:0] off, logic [ByteW-1:0] v);
      int ch;
      if (off < 4'h8) begin
        ch = c * 4 + off[2:1];
        if (off[0])
          count[ch] = byte_hi[c] ? {v, count[ch][7:0]} : {count[ch][15:8], v};
        else
          base[ch] = byte_hi[c] ? {v, base[ch][7:0]} : {base[ch][15:8], v};
        byte_hi[c] = !byte_hi[c];
        return 1'b1;
      end
      case (off)
        OFF_MASK:  mask[c][v[1:0]] = v[2];
        OFF_MODE:  mode[c * 4 + v[1:0]] = v;
        OFF_CLRFF: byte_hi[c] = 1'b0;
        OFF_RESET: begin
          byte_hi[c] = 1'b0;
          mask[c] = '0;
          for (int i = c * 4; i < c * 4 + 4; i++) begin
            base[i]  = '0;
            count[i] = '0;
            page[i]  = '0;
            mode[i]  = '0;
          end
        end
        default: return 1'b0;
      endcase
      return 1'b1;
    endfunction

    function void note_access(logic [CmdW-1:0] c, logic [PortW-1:0] p,
                              logic [ByteW-1:0] d, logic [ChanW-1:0] ch);
      dma_result_t r;
      int pc;
      r = '0;
      case (c)
        CMD_WRITE, CMD_READ: begin
          if (p[7:4] == CTRL0_HI) begin
            if (c == CMD_READ) r.error = 1'b1;
            else r.error = !write_control(0, p[3:0], d);
          end else if (p[7:5] == CTRL1_HI) begin
            // The second controller sits on even addresses; bit 0 is ignored.
            if (c == CMD_READ) r.error = 1'b1;
            else r.error = !write_control(1, p[4:1], d);
          end else if (p[7:4] == PAGE_HI) begin
            case (p[3:0])
              4'h3:    pc = 1;
              4'h1:    pc = 2;
              4'h2:    pc = 3;
              4'hB:    pc = 5;
              4'h9:    pc = 6;
              4'hA:    pc = 7;
              default: pc = -1;
            endcase
            // An unmapped page offset is silently ignored, not an error.
            if (pc >= 0) begin
              if (c == CMD_WRITE) page[pc] = d;
              else r.rdata = page[pc];
            end
          end else begin
            r.error = 1'b1;
          end
        end
        CMD_QUERY: begin
          r.xfer_address = {page[ch], base[ch]};
          r.xfer_length  = LenW'(count[ch]) + 1'b1;
        end
        default: r.error = 1'b1;
      endcase
      expected_results.push_back(r);
    endfunction

    function void check_result(dma_result_t got);
      dma_result_t want;
      if (expected_results.size() == 0) begin
        $error("result word arrived with no access pending");
        failures++;
        return;
      end
      want = expected_results.pop_front();
      if (got.rdata !== want.rdata) begin
        $error("rdata: expected %0h, got %0h", want.rdata, got.rdata);
        failures++;
      end
      if (got.xfer_address !== want.xfer_address) begin
        $error("xfer_address: expected %0h, got %0h", want.xfer_address, got.xfer_address);
        failures++;
      end
      if (got.xfer_length !== want.xfer_length) begin
        $error("xfer_length: expected %0h, got %0h", want.xfer_length, got.xfer_length);
        failures++;
      end
      if (got.error !== want.error) begin
        $error("error: expected %0b, got %0b", want.error, got.error);
        failures++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CmdW-1:0]   cmd = CMD_QUERY;
  logic [PortW-1:0]  port = '0;
  logic [ByteW-1:0]  wdata = '0;
  logic [ChanW-1:0]  channel = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [ByteW-1:0]  rdata;
  logic [AddrW-1:0]  xfer_address;
  logic [LenW-1:0]   xfer_length;
  logic              error;

  dma_scoreboard sb = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int words_sent;
  int quiet_cycles;

  isa_dma_channel_register_file_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .port         (port),
    .wdata        (wdata),
    .channel      (channel),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .rdata        (rdata),
    .xfer_address (xfer_address),
    .xfer_length  (xfer_length),
    .error        (error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side. Outputs are sampled at the edge, before any register in the
  // design updates, so the values seen are the ones the handshake took. The
  // same block throttles out_ready and runs the watchdog, which restarts on
  // every word that moves in either direction.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (out_valid && out_ready)
        sb.check_result('{rdata, xfer_address, xfer_length, error});
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("isa_dma_channel_register_file_top verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Presents one access word and holds it until the block takes it. Valid is
  // only dropped inside the idle loop, so back-to-back words keep it high
  // without a second assignment in the same step.
  task automatic send_access(input logic [CmdW-1:0] c, input logic [PortW-1:0] p,
                             input logic [ByteW-1:0] d, input logic [ChanW-1:0] ch);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    port     <= p;
    wdata    <= d;
    channel  <= ch;
    do @(posedge clk); while (!in_ready);
    sb.note_access(c, p, d, ch);
    words_sent++;
  endtask

  // Port of a control register offset. The second controller decodes its
  // offset from address bits 4:1, so bit 0 is left random there.
  function automatic logic [PortW-1:0] ctl_port(input int c, input logic [3:0] off);
    if (c == 0) return {CTRL0_HI, off};
    return {CTRL1_HI, off, 1'($urandom_range(1))};
  endfunction

  // The usual driver sequence for one channel: reset the byte order, mask the
  // channel, set its mode, load address and count low byte first, set the
  // page, unmask, then ask for the transfer. Now and then the flip-flop clear
  // is left out so that the byte order is whatever the past left behind.
  task automatic program_channel(input logic [ChanW-1:0] ch);
    logic [ByteW-1:0] d;
    int c;
    c = ch[2];
    if ($urandom_range(99) >= 20)
      send_access(CMD_WRITE, ctl_port(c, OFF_CLRFF), 8'($urandom), 3'($urandom));
    d = 8'($urandom);
    d[2:0] = {1'b1, ch[1:0]};
    send_access(CMD_WRITE, ctl_port(c, OFF_MASK), d, 3'($urandom));
    d = 8'($urandom);
    d[1:0] = ch[1:0];
    send_access(CMD_WRITE, ctl_port(c, OFF_MODE), d, 3'($urandom));
    repeat (2) send_access(CMD_WRITE, ctl_port(c, {1'b0, ch[1:0], 1'b0}), 8'($urandom),
                           3'($urandom));
    repeat (2) send_access(CMD_WRITE, ctl_port(c, {1'b0, ch[1:0], 1'b1}), 8'($urandom),
                           3'($urandom));
    send_access(CMD_WRITE, {PAGE_HI, PAGE_OFF_OF_CH[ch]}, 8'($urandom), 3'($urandom));
    d = 8'($urandom);
    d[2:0] = {1'b0, ch[1:0]};
    send_access(CMD_WRITE, ctl_port(c, OFF_MASK), d, 3'($urandom));
    send_access(CMD_QUERY, 8'($urandom), 8'($urandom), ch);
    if ($urandom_range(1) == 1)
      send_access(CMD_READ, {PAGE_HI, PAGE_OFF_OF_CH[ch]}, 8'($urandom), 3'($urandom));
  endtask

  // One arbitrary word: any command, a port aimed at one of the decoded
  // windows or anywhere at all, and random data and channel.
  task automatic send_noise();
    logic [PortW-1:0] p;
    case ($urandom_range(3))
      0:       p = {CTRL0_HI, 4'($urandom)};
      1:       p = {CTRL1_HI, 5'($urandom)};
      2:       p = {PAGE_HI, 4'($urandom)};
      default: p = 8'($urandom);
    endcase
    send_access(2'($urandom_range(3)), p, 8'($urandom), 3'($urandom));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. A query right after reset sees all zeros and a length of
    // one. Channel 3 is then loaded with all ones everywhere, which gives the
    // largest address and the largest length of 65536.
    send_access(CMD_QUERY, 8'h00, 8'h00, 3'd0);
    repeat (2) send_access(CMD_WRITE, ctl_port(0, {1'b0, 2'd3, 1'b0}), 8'hFF, 3'd7);
    repeat (2) send_access(CMD_WRITE, ctl_port(0, {1'b0, 2'd3, 1'b1}), 8'hFF, 3'd7);
    send_access(CMD_WRITE, {PAGE_HI, PAGE_OFF_OF_CH[3]}, 8'hFF, 3'd0);
    send_access(CMD_QUERY, 8'hFF, 8'hFF, 3'd3);
    send_access(CMD_READ, {PAGE_HI, PAGE_OFF_OF_CH[3]}, 8'h00, 3'd0);
    // Unmapped page offsets: the write is dropped, the read returns zero.
    send_access(CMD_WRITE, {PAGE_HI, 4'hF}, 8'hA5, 3'd0);
    send_access(CMD_READ, {PAGE_HI, 4'h0}, 8'h00, 3'd0);
    // Control port reads, bad offsets, unmapped ports and an undefined command.
    send_access(CMD_READ, ctl_port(0, 4'h0), 8'h00, 3'd0);
    send_access(CMD_READ, ctl_port(1, OFF_MODE), 8'h00, 3'd0);
    send_access(CMD_WRITE, ctl_port(0, 4'hF), 8'h00, 3'd0);
    send_access(CMD_WRITE, ctl_port(1, 4'h8), 8'hFF, 3'd0);
    send_access(CMD_WRITE, 8'h20, 8'h00, 3'd0);
    send_access(CMD_READ, 8'hFF, 8'hFF, 3'd7);
    send_access(CMD_UNDEF, ctl_port(0, 4'h0), 8'hFF, 3'd3);
    // Mask set and clear and a mode write on the first controller.
    send_access(CMD_WRITE, ctl_port(0, OFF_MASK), 8'h07, 3'd0);
    send_access(CMD_WRITE, ctl_port(0, OFF_MASK), 8'h03, 3'd0);
    send_access(CMD_WRITE, ctl_port(0, OFF_MODE), 8'hFF, 3'd0);
    // Second controller: a stray byte leaves the flip-flop on the high byte,
    // the clear puts it back, then channel 7 is loaded and queried. A
    // controller reset wipes channel 7 but leaves channel 3 alone.
    send_access(CMD_WRITE, ctl_port(1, {1'b0, 2'd3, 1'b0}), 8'h5A, 3'd0);
    send_access(CMD_WRITE, ctl_port(1, OFF_CLRFF), 8'h00, 3'd0);
    send_access(CMD_WRITE, ctl_port(1, {1'b0, 2'd3, 1'b0}), 8'h12, 3'd0);
    send_access(CMD_WRITE, {PAGE_HI, PAGE_OFF_OF_CH[7]}, 8'h56, 3'd0);
    send_access(CMD_QUERY, 8'h00, 8'h00, 3'd7);
    send_access(CMD_WRITE, ctl_port(1, OFF_RESET), 8'h00, 3'd0);
    send_access(CMD_QUERY, 8'h00, 8'h00, 3'd7);
    send_access(CMD_QUERY, 8'h00, 8'h00, 3'd3);

    // Random part, one stretch per idling mix. Most words come in channel
    // programming sequences so that queries see loaded registers; the rest is
    // noise that also knocks the byte order and the controllers about.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = SEND_IDLE[ph];
      recv_stall_pct = RECV_STALL[ph];
      words_sent = 0;
      while (words_sent < WORDS_PER_PHASE) begin
        if ($urandom_range(99) < 65) program_channel(3'($urandom));
        else send_noise();
      end
    end

    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    // The wait that follows catches any extra word.
    repeat (8) @(posedge clk);

    if (sb.expected_results.size() != 0) begin
      $error("%0d result words never arrived", sb.expected_results.size());
      sb.failures++;
    end
    if (sb.failures == 0)
      $display("isa_dma_channel_register_file_top verification clean");
    else
      $display("isa_dma_channel_register_file_top verification failed");
    $finish;
  end

endmodule
